>>> hw/rtl/sgi_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, status codes and shared types for the segment intersection core.
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int C   = 16;
    localparam int DW  = C + 1;
    localparam int PW  = 2 * C;
    localparam int CW  = 2 * C + 1;
    localparam int SPW = DW + C;
    localparam int SW  = 2 * C + 3;
    localparam int DPW = 2 * DW;
    localparam int DNW = 2 * DW + 1;
    localparam int NPW = DW + CW;
    localparam int NW  = 3 * C + 3;
    localparam int MW  = NW;
    localparam int DM  = DNW;
    localparam int QB  = C + 2;
    localparam int NS  = 5 + QB + 1;

    typedef logic [1:0] status_t;

    localparam status_t ST_NONE     = 2'd0;
    localparam status_t ST_CROSS    = 2'd1;
    localparam status_t ST_PARALLEL = 2'd2;

endpackage

>>> hw/rtl/segment_intersection_core.sv
// ----------------------------------------------------------------------------
// Segment intersection core
// Tests two segments for a crossing and gives the rounded crossing point.
// ----------------------------------------------------------------------------
// A request passes through the compute stages, the divider stages and the output stage.
// One request is accepted every cycle unless in_stall is raised; the restoring divider stages set the depth.
// A stalled output lets empty stages behind it keep filling.
// Reset clears all valid bits; the data registers are not reset.
module segment_intersection_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [sgi_pkg::C-1:0]  ax0,
    input  logic signed [sgi_pkg::C-1:0]  ay0,
    input  logic signed [sgi_pkg::C-1:0]  ax1,
    input  logic signed [sgi_pkg::C-1:0]  ay1,
    input  logic signed [sgi_pkg::C-1:0]  bx0,
    input  logic signed [sgi_pkg::C-1:0]  by0,
    input  logic signed [sgi_pkg::C-1:0]  bx1,
    input  logic signed [sgi_pkg::C-1:0]  by1,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sgi_pkg::status_t              status,
    output logic signed [sgi_pkg::C-1:0]  cross_x,
    output logic signed [sgi_pkg::C-1:0]  cross_y
);
    import sgi_pkg::*;

    function automatic logic same_side(input logic signed [SW-1:0] r,
                                       input logic signed [SW-1:0] s);
        same_side = (r != '0) && (s != '0) && (r[SW-1] == s[SW-1]);
    endfunction

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: line coefficients and endpoint cross products.
    logic signed [C-1:0]  s1_ax0_reg, s1_ay0_reg, s1_ax1_reg, s1_ay1_reg;
    logic signed [C-1:0]  s1_bx0_reg, s1_by0_reg, s1_bx1_reg, s1_by1_reg;
    logic signed [DW-1:0] s1_ea_reg, s1_eb_reg, s1_fa_reg, s1_fb_reg;
    logic signed [PW-1:0] s1_pa1_reg, s1_pa2_reg, s1_pb1_reg, s1_pb2_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s1_ax0_reg <= ax0;
            s1_ay0_reg <= ay0;
            s1_ax1_reg <= ax1;
            s1_ay1_reg <= ay1;
            s1_bx0_reg <= bx0;
            s1_by0_reg <= by0;
            s1_bx1_reg <= bx1;
            s1_by1_reg <= by1;
            s1_ea_reg  <= DW'(ay1) - DW'(ay0);
            s1_eb_reg  <= DW'(ax0) - DW'(ax1);
            s1_fa_reg  <= DW'(by1) - DW'(by0);
            s1_fb_reg  <= DW'(bx0) - DW'(bx1);
            s1_pa1_reg <= PW'(ax1) * PW'(ay0);
            s1_pa2_reg <= PW'(ax0) * PW'(ay1);
            s1_pb1_reg <= PW'(bx1) * PW'(by0);
            s1_pb2_reg <= PW'(bx0) * PW'(by1);
        end
    end

    // Stage 2: line constants and side products.
    logic signed [DW-1:0]  s2_ea_reg, s2_eb_reg, s2_fa_reg, s2_fb_reg;
    logic signed [CW-1:0]  s2_ec_reg, s2_fc_reg;
    logic signed [SPW-1:0] s2_a1_reg, s2_a2_reg, s2_a3_reg, s2_a4_reg;
    logic signed [SPW-1:0] s2_b1_reg, s2_b2_reg, s2_b3_reg, s2_b4_reg;
    logic signed [DPW-1:0] s2_d1_reg, s2_d2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s2_ea_reg <= s1_ea_reg;
            s2_eb_reg <= s1_eb_reg;
            s2_fa_reg <= s1_fa_reg;
            s2_fb_reg <= s1_fb_reg;
            s2_ec_reg <= CW'(s1_pa1_reg) - CW'(s1_pa2_reg);
            s2_fc_reg <= CW'(s1_pb1_reg) - CW'(s1_pb2_reg);
            s2_a1_reg <= SPW'(s1_ea_reg) * SPW'(s1_bx0_reg);
            s2_a2_reg <= SPW'(s1_eb_reg) * SPW'(s1_by0_reg);
            s2_a3_reg <= SPW'(s1_ea_reg) * SPW'(s1_bx1_reg);
            s2_a4_reg <= SPW'(s1_eb_reg) * SPW'(s1_by1_reg);
            s2_b1_reg <= SPW'(s1_fa_reg) * SPW'(s1_ax0_reg);
            s2_b2_reg <= SPW'(s1_fb_reg) * SPW'(s1_ay0_reg);
            s2_b3_reg <= SPW'(s1_fa_reg) * SPW'(s1_ax1_reg);
            s2_b4_reg <= SPW'(s1_fb_reg) * SPW'(s1_ay1_reg);
            s2_d1_reg <= DPW'(s1_ea_reg) * DPW'(s1_fb_reg);
            s2_d2_reg <= DPW'(s1_fa_reg) * DPW'(s1_eb_reg);
        end
    end

    // Stage 3: side values, denominator and numerator products.
    logic signed [SW-1:0]  s3_ra_reg, s3_sa_reg, s3_rb_reg, s3_sb_reg;
    logic signed [DNW-1:0] s3_den_reg;
    logic signed [NPW-1:0] s3_n1_reg, s3_n2_reg, s3_n3_reg, s3_n4_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s3_ra_reg  <= SW'(s2_a1_reg) + SW'(s2_a2_reg) + SW'(s2_ec_reg);
            s3_sa_reg  <= SW'(s2_a3_reg) + SW'(s2_a4_reg) + SW'(s2_ec_reg);
            s3_rb_reg  <= SW'(s2_b1_reg) + SW'(s2_b2_reg) + SW'(s2_fc_reg);
            s3_sb_reg  <= SW'(s2_b3_reg) + SW'(s2_b4_reg) + SW'(s2_fc_reg);
            s3_den_reg <= DNW'(s2_d1_reg) - DNW'(s2_d2_reg);
            s3_n1_reg  <= NPW'(s2_eb_reg) * NPW'(s2_fc_reg);
            s3_n2_reg  <= NPW'(s2_fb_reg) * NPW'(s2_ec_reg);
            s3_n3_reg  <= NPW'(s2_fa_reg) * NPW'(s2_ec_reg);
            s3_n4_reg  <= NPW'(s2_ea_reg) * NPW'(s2_fc_reg);
        end
    end

    // Stage 4: status decision and numerators.
    status_t               s4_st_reg;
    status_t               s4_st_next;
    logic signed [NW-1:0]  s4_nx_reg, s4_ny_reg;
    logic signed [DNW-1:0] s4_den_reg;

    always_comb
    begin
        if (same_side(s3_ra_reg, s3_sa_reg) || same_side(s3_rb_reg, s3_sb_reg))
        begin
            s4_st_next = ST_NONE;
        end
        else if (s3_den_reg == '0)
        begin
            s4_st_next = ST_PARALLEL;
        end
        else
        begin
            s4_st_next = ST_CROSS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s4_st_reg  <= s4_st_next;
            s4_nx_reg  <= NW'(s3_n1_reg) - NW'(s3_n2_reg);
            s4_ny_reg  <= NW'(s3_n3_reg) - NW'(s3_n4_reg);
            s4_den_reg <= s3_den_reg;
        end
    end

    // Stage 5: magnitudes with the rounding half added.
    logic [MW-1:0] s5_mx_reg, s5_my_reg;
    logic [DM-1:0] s5_d_reg;
    logic          s5_negx_reg, s5_negy_reg;
    status_t       s5_st_reg;
    logic [MW-1:0] ax_abs, ay_abs;
    logic [DM-1:0] d_abs;

    always_comb
    begin
        ax_abs = s4_nx_reg[NW-1] ? MW'(-s4_nx_reg) : MW'(s4_nx_reg);
        ay_abs = s4_ny_reg[NW-1] ? MW'(-s4_ny_reg) : MW'(s4_ny_reg);
        d_abs  = s4_den_reg[DNW-1] ? DM'(-s4_den_reg) : DM'(s4_den_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s5_mx_reg   <= ax_abs + MW'(d_abs >> 1);
            s5_my_reg   <= ay_abs + MW'(d_abs >> 1);
            s5_d_reg    <= d_abs;
            s5_negx_reg <= s4_nx_reg[NW-1] ^ s4_den_reg[DNW-1];
            s5_negy_reg <= s4_ny_reg[NW-1] ^ s4_den_reg[DNW-1];
            s5_st_reg   <= s4_st_reg;
        end
    end

    // Divider stages: one restoring quotient bit per stage for each axis.
    logic [DM-1:0] dv_rx_reg [QB];
    logic [DM-1:0] dv_ry_reg [QB];
    logic [QB-1:0] dv_qx_reg [QB];
    logic [QB-1:0] dv_qy_reg [QB];
    logic [MW-1:0] dv_mx_reg [QB];
    logic [MW-1:0] dv_my_reg [QB];
    logic [DM-1:0] dv_d_reg  [QB];
    logic          dv_negx_reg [QB];
    logic          dv_negy_reg [QB];
    status_t       dv_st_reg [QB];

    logic [DM-1:0] dv_rx_next [QB];
    logic [DM-1:0] dv_ry_next [QB];
    logic [QB-1:0] dv_qx_next [QB];
    logic [QB-1:0] dv_qy_next [QB];

    always_comb
    begin
        logic [DM-1:0] rx, ry, d;
        logic [QB-1:0] qx, qy;
        logic [MW-1:0] mx, my;
        logic [DM:0]   tx, ty;
        for (int j = 0; j < QB; j++)
        begin
            if (j == 0)
            begin
                rx = DM'(s5_mx_reg[MW-1:QB]);
                ry = DM'(s5_my_reg[MW-1:QB]);
                qx = '0;
                qy = '0;
                mx = s5_mx_reg;
                my = s5_my_reg;
                d  = s5_d_reg;
            end
            else
            begin
                rx = dv_rx_reg[j-1];
                ry = dv_ry_reg[j-1];
                qx = dv_qx_reg[j-1];
                qy = dv_qy_reg[j-1];
                mx = dv_mx_reg[j-1];
                my = dv_my_reg[j-1];
                d  = dv_d_reg[j-1];
            end
            tx = {rx, mx[QB-1-j]};
            ty = {ry, my[QB-1-j]};
            if (tx >= {1'b0, d})
            begin
                dv_rx_next[j] = DM'(tx - {1'b0, d});
                dv_qx_next[j] = {qx[QB-2:0], 1'b1};
            end
            else
            begin
                dv_rx_next[j] = DM'(tx);
                dv_qx_next[j] = {qx[QB-2:0], 1'b0};
            end
            if (ty >= {1'b0, d})
            begin
                dv_ry_next[j] = DM'(ty - {1'b0, d});
                dv_qy_next[j] = {qy[QB-2:0], 1'b1};
            end
            else
            begin
                dv_ry_next[j] = DM'(ty);
                dv_qy_next[j] = {qy[QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < QB; j++)
        begin
            if (en[5+j])
            begin
                dv_rx_reg[j] <= dv_rx_next[j];
                dv_ry_reg[j] <= dv_ry_next[j];
                dv_qx_reg[j] <= dv_qx_next[j];
                dv_qy_reg[j] <= dv_qy_next[j];
                if (j == 0)
                begin
                    dv_mx_reg[j]   <= s5_mx_reg;
                    dv_my_reg[j]   <= s5_my_reg;
                    dv_d_reg[j]    <= s5_d_reg;
                    dv_negx_reg[j] <= s5_negx_reg;
                    dv_negy_reg[j] <= s5_negy_reg;
                    dv_st_reg[j]   <= s5_st_reg;
                end
                else
                begin
                    dv_mx_reg[j]   <= dv_mx_reg[j-1];
                    dv_my_reg[j]   <= dv_my_reg[j-1];
                    dv_d_reg[j]    <= dv_d_reg[j-1];
                    dv_negx_reg[j] <= dv_negx_reg[j-1];
                    dv_negy_reg[j] <= dv_negy_reg[j-1];
                    dv_st_reg[j]   <= dv_st_reg[j-1];
                end
            end
        end
    end

    // Output stage: signs applied, coordinates cleared unless the segments cross.
    status_t             st_reg;
    logic signed [C-1:0] cx_reg, cy_reg;
    logic [QB-1:0]       qx_sgn, qy_sgn;

    always_comb
    begin
        qx_sgn = dv_negx_reg[QB-1] ? -dv_qx_reg[QB-1] : dv_qx_reg[QB-1];
        qy_sgn = dv_negy_reg[QB-1] ? -dv_qy_reg[QB-1] : dv_qy_reg[QB-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            st_reg <= dv_st_reg[QB-1];
            if (dv_st_reg[QB-1] == ST_CROSS)
            begin
                cx_reg <= qx_sgn[C-1:0];
                cy_reg <= qy_sgn[C-1:0];
            end
            else
            begin
                cx_reg <= '0;
                cy_reg <= '0;
            end
        end
    end

    assign status  = st_reg;
    assign cross_x = cx_reg;
    assign cross_y = cy_reg;

endmodule

>>> hw/rtl/sgi_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection checker
// Port-level checks on the segment intersection core, bound to the core module.
// ----------------------------------------------------------------------------
module sgi_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  sgi_pkg::status_t              status,
    input  logic signed [sgi_pkg::C-1:0]  cross_x,
    input  logic signed [sgi_pkg::C-1:0]  cross_y
);
    import sgi_pkg::*;

    a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_CROSS) |-> (cross_x == '0) && (cross_y == '0))
        else $error("coordinates not cleared without a crossing");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(cross_x)
            && $stable(cross_y))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output is empty");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

endmodule

bind segment_intersection_core sgi_checker u_sgi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
);

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Segment intersection core testbench
// Drives segment pairs through the core with random idle and stall cycles,
// predicts status and rounded crossing point for each request with exact
// wide arithmetic, and compares every result in order.
// ----------------------------------------------------------------------------
module testbench;

    import sgi_pkg::*;

    localparam int N_RANDOM  = 1900;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 40;

    typedef logic signed [C-1:0] coord_t;

    typedef struct {
        coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef struct {
        status_t st;
        coord_t  x;
        coord_t  y;
    } crossing_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    coord_t  ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic    out_valid;
    logic    out_stall;
    status_t status;
    coord_t  cross_x, cross_y;

    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        n_cross;
    int        n_parallel;
    int        quiet_cycles;
    bit        no_idle;
    bit        hold_off;

    segment_intersection_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ax0       (ax0),
        .ay0       (ay0),
        .ax1       (ax1),
        .ay1       (ay1),
        .bx0       (bx0),
        .by0       (by0),
        .bx1       (bx1),
        .by1       (by1),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cross_x   (cross_x),
        .cross_y   (cross_y)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic coord_t round_quotient(logic signed [127:0] num,
                                              logic signed [127:0] den);
        logic signed [127:0] mn;
        logic signed [127:0] md;
        logic signed [127:0] q;
        begin
            mn = (num < 0) ? -num : num;
            md = (den < 0) ? -den : den;
            q = (mn + (md >>> 1)) / md;
            if ((num < 0) != (den < 0))
                q = -q;
            return q[C-1:0];
        end
    endfunction

    function automatic bit strictly_same_side(logic signed [127:0] r,
                                              logic signed [127:0] s);
        return r != 0 && s != 0 && ((r > 0) == (s > 0));
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t p);
        logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
        logic signed [127:0] ea, eb, ec, fa, fb, fc, den;
        crossing_t r;
        begin
            x1 = 128'(p.ax0); y1 = 128'(p.ay0); x2 = 128'(p.ax1); y2 = 128'(p.ay1);
            x3 = 128'(p.bx0); y3 = 128'(p.by0); x4 = 128'(p.bx1); y4 = 128'(p.by1);
            r.st = ST_NONE;
            r.x = '0;
            r.y = '0;
            ea = y2 - y1;
            eb = x1 - x2;
            ec = x2 * y1 - x1 * y2;
            if (strictly_same_side(ea * x3 + eb * y3 + ec, ea * x4 + eb * y4 + ec))
                return r;
            fa = y4 - y3;
            fb = x3 - x4;
            fc = x4 * y3 - x3 * y4;
            if (strictly_same_side(fa * x1 + fb * y1 + fc, fa * x2 + fb * y2 + fc))
                return r;
            den = ea * fb - fa * eb;
            if (den == 0)
            begin
                r.st = ST_PARALLEL;
                return r;
            end
            r.st = ST_CROSS;
            r.x = round_quotient(eb * fc - fb * ec, den);
            r.y = round_quotient(fa * ec - ea * fc, den);
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 n_checked, what, got, want);
        n_errors++;
    endtask

    function automatic coord_t rand_coord(int mode);
        case (mode)
            0: return coord_t'($urandom);
            1: return coord_t'(int'($urandom_range(0, 64)) - 32);
            default: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    task automatic queue_pair(int a0, int b0, int a1, int b1,
                              int c0, int d0, int c1, int d1);
        seg_pair_t p;
        begin
            p.ax0 = coord_t'(a0); p.ay0 = coord_t'(b0);
            p.ax1 = coord_t'(a1); p.ay1 = coord_t'(b1);
            p.bx0 = coord_t'(c0); p.by0 = coord_t'(d0);
            p.bx1 = coord_t'(c1); p.by1 = coord_t'(d1);
            pending_pairs.insert(pending_pairs.size(), p);
        end
    endtask

    // Random pairs: many are built to cross by drawing B through a point on A.
    task automatic queue_random_pair();
        seg_pair_t p;
        int        mode;
        begin
            mode = $urandom_range(0, 2);
            p.ax0 = rand_coord(mode); p.ay0 = rand_coord(mode);
            p.ax1 = rand_coord(mode); p.ay1 = rand_coord(mode);
            p.bx0 = rand_coord(mode); p.by0 = rand_coord(mode);
            p.bx1 = rand_coord(mode); p.by1 = rand_coord(mode);
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    p.bx1 = coord_t'(int'(p.ax0) + int'(p.ax1) - int'(p.bx0));
                    p.by1 = coord_t'(int'(p.ay0) + int'(p.ay1) - int'(p.by0));
                    if (mode == 0)
                    begin
                        p.bx1 = coord_t'((int'(p.ax0) + int'(p.ax1)) / 2);
                        p.by1 = coord_t'((int'(p.ay0) + int'(p.ay1)) / 2);
                        p.bx0 = coord_t'(-int'(p.bx1) + 2 * (int'(p.bx1) / 2));
                    end
                end
                4:
                begin
                    p.bx0 = coord_t'(int'(p.ax0) + (int'(p.ax1) - int'(p.ax0)) * 2);
                    p.by0 = coord_t'(int'(p.ay0) + (int'(p.ay1) - int'(p.ay0)) * 2);
                    p.bx1 = p.ax1; p.by1 = p.ay1;
                end
                5:
                begin
                    p.bx0 = coord_t'(int'(p.ax0) + 3); p.by0 = p.ay0;
                    p.bx1 = coord_t'(int'(p.ax1) + 3); p.by1 = p.ay1;
                end
                default: ;
            endcase
            pending_pairs.insert(pending_pairs.size(), p);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_crossings.insert(expected_crossings.size(),
                                          predict_crossing(pending_pairs.pop_front()));
                n_sent++;
            end
            if ((!in_valid || !in_stall))
            begin
                if (pending_pairs.size() > 0 && !hold_off
                    && (no_idle || $urandom_range(0, 99) >= 16))
                begin
                    in_valid <= 1'b1;
                    ax0 <= pending_pairs[0].ax0; ay0 <= pending_pairs[0].ay0;
                    ax1 <= pending_pairs[0].ax1; ay1 <= pending_pairs[0].ay1;
                    bx0 <= pending_pairs[0].bx0; by0 <= pending_pairs[0].by0;
                    bx1 <= pending_pairs[0].bx1; by1 <= pending_pairs[0].by1;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            crossing_t e;
            if (expected_crossings.size() == 0)
            begin
                $display("unexpected result with status %0d", status);
                n_errors++;
            end
            else
            begin
                e = expected_crossings.pop_front();
                if (status !== e.st)
                    report_mismatch("status", int'(status), int'(e.st));
                if (cross_x !== e.x)
                    report_mismatch("cross_x", int'(cross_x), int'(e.x));
                if (cross_y !== e.y)
                    report_mismatch("cross_y", int'(cross_y), int'(e.y));
                if (e.st == ST_CROSS)
                    n_cross++;
                if (e.st == ST_PARALLEL)
                    n_parallel++;
            end
            n_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("watchdog expired with %0d results outstanding",
                     expected_crossings.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {ax0, ay0, ax1, ay1, bx0, by0, bx1, by1} = '0;
        n_errors = 0; n_sent = 0; n_checked = 0; n_cross = 0; n_parallel = 0;
        quiet_cycles = 0;
        no_idle = 1'b0;
        hold_off = 1'b0;

        // Extremes, a plain cross, half-way rounding, touching ends,
        // parallel and collinear lines, degenerate points.
        queue_pair(0, 0, 0, 0, 0, 0, 0, 0);
        queue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        queue_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
        queue_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        queue_pair(0, 0, 4, 4, 0, 4, 4, 0);
        queue_pair(0, 0, 1, 1, 0, 1, 1, 0);
        queue_pair(0, 0, -1, -1, 0, -1, -1, 0);
        queue_pair(0, 0, 3, 0, 1, -1, 2, 2);
        queue_pair(0, 0, 4, 0, 4, 0, 4, 5);
        queue_pair(0, 0, 4, 0, 2, 0, 2, 5);
        queue_pair(0, 0, 4, 0, 0, 1, 4, 1);
        queue_pair(0, 0, 4, 0, 2, 0, 8, 0);
        queue_pair(0, 0, 4, 0, 6, 0, 8, 0);
        queue_pair(0, 0, 4, 0, 0, 2, 4, 3);
        queue_pair(3, 3, 3, 3, 0, 0, 6, 6);
        queue_pair(3, 3, 3, 3, 3, 3, 3, 3);
        queue_pair(1, 1, 1, 1, 5, 5, 5, 5);
        queue_pair(-32768, 32767, 32767, -32768, -32768, -32768, 32767, 32767);
        queue_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        queue_pair(0, -3, 0, 3, -5, -2, 5, 1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                wait (pending_pairs.size() == 0);
                @(posedge clk);
                hold_off <= 1'b1;
                wait (expected_crossings.size() == 0 && !in_valid);
                @(posedge clk);
                hold_off <= 1'b0;
                no_idle <= 1'b1;
            end
            if (i == N_RANDOM / 2 + 300)
            begin
                wait (pending_pairs.size() == 0);
                @(posedge clk);
                no_idle <= 1'b0;
            end
            queue_random_pair();
        end

        wait (pending_pairs.size() == 0 && !in_valid);
        wait (expected_crossings.size() == 0);
        repeat (SETTLE) @(posedge clk);

        $display("checked %0d results for %0d requests: %0d crossings, %0d parallel",
                 n_checked, n_sent, n_cross, n_parallel);
        $display("including extreme coordinates, touching ends and random idle and stall");
        if (n_errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
